>>> sv/mcte_pkg.sv
package mcte_pkg;

  // Field widths of the sample and of the estimate.
  localparam int CNT_W = 48;
  localparam int EST_W = 63;
  localparam int SUM_W = 65;

  // Position within a series.
  localparam logic [1:0] POS_EMPTY = 2'd0;
  localparam logic [1:0] POS_FIRST = 2'd1;
  localparam logic [1:0] POS_RUN   = 2'd2;

  // Limits of the estimate and of the corrected delta magnitude.
  localparam logic signed [EST_W-1:0] EST_MAX = {1'b0, {(EST_W-1){1'b1}}};
  localparam logic signed [EST_W-1:0] EST_MIN = {1'b1, {(EST_W-1){1'b0}}};
  localparam logic [63:0]             MAG_LIM = 64'h8000_0000_0000_0000;

  // One counter sample.
  typedef struct packed {
    logic [CNT_W-1:0] raw_count;
    logic [CNT_W-1:0] time_enabled;
    logic [CNT_W-1:0] time_running;
    logic             start_series;
  } in_item_t;

  // One estimate.
  typedef struct packed {
    logic signed [EST_W-1:0] estimated_count;
    logic                    saturated;
  } out_item_t;

endpackage

>>> sv/multiplexed_counter_trapezoid_estimator.sv
// Multiplexed counter estimator: each item is one sample (raw count, time enabled, time
// running) and produces one item holding the running corrected count estimate, saturated
// to 63 bits signed. Below, CB is COUNTER_BITS capped at the 48-bit port width. The first
// sample of a series goes from acceptance straight to the final step, which writes the
// output register, and the next item can be accepted in the idle state after that step.
// Every later sample is worked on by one shared adder. It runs ten setup steps, then a
// shift-and-add multiply of one bit per cycle over CB bits. Then comes one magnitude step
// and a restoring divide of one quotient bit per cycle over 2*CB+2 bits. A clamp step, a
// final add and the final step that writes the output register close the item. in_stall
// is high while an item is being worked on. A finished result waits in the output
// register and does not hold up the acceptance of the next item. If a result is still
// held there when the next one is done, the block waits in its final step for as long
// as out_stall stays high.
module multiplexed_counter_trapezoid_estimator #(
  parameter int COUNTER_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mcte_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mcte_pkg::out_item_t  out_data
);

  // Working widths follow the counter width, capped at the port width.
  localparam int CB   = (COUNTER_BITS < mcte_pkg::CNT_W) ? COUNTER_BITS : mcte_pkg::CNT_W;
  localparam int DW   = CB + 1;
  localparam int NW   = 2 * CB + 2;
  localparam int AW   = (2 * CB + 3 > 66) ? 2 * CB + 3 : 66;
  localparam int CNTW = $clog2(NW + 1);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_DC    = 17'h00002,
    S_DTE   = 17'h00004,
    S_DTR   = 17'h00008,
    S_SUM   = 17'h00010,
    S_DIF   = 17'h00020,
    S_MTE   = 17'h00040,
    S_MTR   = 17'h00080,
    S_T1    = 17'h00100,
    S_T2    = 17'h00200,
    S_T12   = 17'h00400,
    S_MUL   = 17'h00800,
    S_NMAG  = 17'h01000,
    S_DIV   = 17'h02000,
    S_CLAMP = 17'h04000,
    S_ADD   = 17'h08000,
    S_FIN   = 17'h10000
  } state_t;

  state_t state_r, state_nxt;

  // Current sample and history.
  logic [CB-1:0]                     raw_r, te_r, tr_r;
  logic [CB-1:0]                     last_raw_r, last_te_r, last_tr_r;
  logic signed [DW-1:0]              last_dc_r;
  logic signed [mcte_pkg::EST_W-1:0] est_r;
  logic [1:0]                        pos_r;
  logic                              first_r;

  // Working registers.
  logic signed [DW-1:0]              dc_r, dte_r, dtr_r;
  logic [CB-1:0]                     mte_r, mtr_r;
  logic signed [CB+1:0]              s_r, d_r, t1_r, t2_r;
  logic signed [CB+2:0]              t12_r;
  logic signed [NW:0]                acc_r;
  logic [NW-1:0]                     work_r;
  logic [CB:0]                       rem_r;
  logic                              qneg_r;
  logic [63:0]                       mag_r;
  logic signed [mcte_pkg::SUM_W-1:0] sum_r;
  logic [CNTW-1:0]                   cnt_r;

  // Output register.
  logic                              out_valid_r;
  mcte_pkg::out_item_t               out_data_r;

  // Shared adder.
  logic signed [AW-1:0]              alu_a, alu_b, alu_y;
  logic                              alu_sub;

  logic                              pos_first;
  logic                              dtr_zero;
  logic signed [DW-1:0]              dte_e, dtr_e;
  logic signed [CB+2:0]              mul_term;
  logic [CB:0]                       den;
  logic                              est_fits;
  logic signed [mcte_pkg::EST_W-1:0] est_clip;
  logic                              out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  // A zero running delta means a ratio of one.
  assign pos_first = (pos_r == mcte_pkg::POS_FIRST);
  assign dtr_zero  = (dtr_r == '0);
  assign dte_e     = dtr_zero ? DW'(1) : dte_r;
  assign dtr_e     = dtr_zero ? DW'(1) : dtr_r;
  assign den       = {mtr_r, 1'b0};

  // Partial product picked by the current bits of both multiplier magnitudes.
  always_comb begin
    case ({mte_r[CB-1], mtr_r[CB-1]})
      2'b10:   mul_term = (CB+3)'(t1_r);
      2'b01:   mul_term = (CB+3)'(t2_r);
      2'b11:   mul_term = t12_r;
      default: mul_term = '0;
    endcase
  end

  // Operand selection for the shared adder.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_r)
      S_DC: begin
        alu_a   = AW'(raw_r);
        alu_b   = AW'(last_raw_r);
        alu_sub = 1'b1;
      end
      S_DTE: begin
        alu_a   = AW'(te_r);
        alu_b   = AW'(last_te_r);
        alu_sub = 1'b1;
      end
      S_DTR: begin
        alu_a   = AW'(tr_r);
        alu_b   = AW'(last_tr_r);
        alu_sub = 1'b1;
      end
      S_SUM: begin
        alu_a = pos_first ? '0 : AW'(last_dc_r);
        alu_b = AW'(dc_r);
      end
      S_DIF: begin
        alu_a   = pos_first ? '0 : AW'(last_dc_r);
        alu_b   = pos_first ? '0 : AW'(dc_r);
        alu_sub = 1'b1;
      end
      S_MTE: begin
        alu_b   = AW'(dte_e);
        alu_sub = dte_e[DW-1];
      end
      S_MTR: begin
        alu_b   = AW'(dtr_e);
        alu_sub = dtr_e[DW-1];
      end
      S_T1: begin
        alu_b   = AW'(s_r);
        alu_sub = dte_e[DW-1];
      end
      S_T2: begin
        alu_b   = AW'(d_r);
        alu_sub = dtr_e[DW-1];
      end
      S_T12: begin
        alu_a = AW'(t1_r);
        alu_b = AW'(t2_r);
      end
      S_MUL: begin
        alu_a = AW'(acc_r) <<< 1;
        alu_b = AW'(mul_term);
      end
      S_NMAG: begin
        alu_b   = AW'(acc_r);
        alu_sub = acc_r[NW];
      end
      S_DIV: begin
        alu_a   = AW'({rem_r, work_r[NW-1]});
        alu_b   = AW'(den);
        alu_sub = 1'b1;
      end
      S_CLAMP: begin
        alu_a   = AW'(mcte_pkg::MAG_LIM);
        alu_b   = AW'(work_r);
        alu_sub = 1'b1;
      end
      S_ADD: begin
        alu_a   = AW'(est_r);
        alu_b   = AW'(mag_r);
        alu_sub = qneg_r;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  // Saturation of the new estimate to the 63-bit range.
  assign est_fits = (sum_r[mcte_pkg::SUM_W-1 -: 3] == 3'b000) ||
                    (sum_r[mcte_pkg::SUM_W-1 -: 3] == 3'b111);
  assign est_clip = est_fits ? sum_r[mcte_pkg::EST_W-1:0] :
                    (sum_r[mcte_pkg::SUM_W-1] ? mcte_pkg::EST_MIN : mcte_pkg::EST_MAX);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.start_series || pos_r == mcte_pkg::POS_EMPTY) ? S_FIN : S_DC;
        end
      end
      S_DC:    state_nxt = S_DTE;
      S_DTE:   state_nxt = S_DTR;
      S_DTR:   state_nxt = S_SUM;
      S_SUM:   state_nxt = S_DIF;
      S_DIF:   state_nxt = S_MTE;
      S_MTE:   state_nxt = S_MTR;
      S_MTR:   state_nxt = S_T1;
      S_T1:    state_nxt = S_T2;
      S_T2:    state_nxt = S_T12;
      S_T12:   state_nxt = S_MUL;
      S_MUL: begin
        if (cnt_r == CNTW'(1)) begin
          state_nxt = S_NMAG;
        end
      end
      S_NMAG:  state_nxt = S_DIV;
      S_DIV: begin
        if (cnt_r == CNTW'(1)) begin
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: state_nxt = S_ADD;
      S_ADD:   state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= mcte_pkg::POS_EMPTY;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FIN && out_free) begin
        pos_r       <= first_r ? mcte_pkg::POS_FIRST : mcte_pkg::POS_RUN;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          raw_r   <= in_data.raw_count[CB-1:0];
          te_r    <= in_data.time_enabled[CB-1:0];
          tr_r    <= in_data.time_running[CB-1:0];
          first_r <= in_data.start_series || (pos_r == mcte_pkg::POS_EMPTY);
        end
      end
      S_DC:  dc_r  <= alu_y[DW-1:0];
      S_DTE: dte_r <= alu_y[DW-1:0];
      S_DTR: dtr_r <= alu_y[DW-1:0];
      S_SUM: s_r   <= alu_y[CB+1:0];
      S_DIF: d_r   <= alu_y[CB+1:0];
      S_MTE: mte_r <= alu_y[CB-1:0];
      S_MTR: mtr_r <= alu_y[CB-1:0];
      S_T1:  t1_r  <= alu_y[CB+1:0];
      S_T2:  t2_r  <= alu_y[CB+1:0];
      S_T12: begin
        t12_r <= alu_y[CB+2:0];
        acc_r <= '0;
        cnt_r <= CNTW'(CB);
      end
      // One multiplier bit of each magnitude per cycle, most significant first. The
      // running-time magnitude rotates, so it is whole again for the divide.
      S_MUL: begin
        acc_r <= alu_y[NW:0];
        mte_r <= mte_r << 1;
        mtr_r <= {mtr_r[CB-2:0], mtr_r[CB-1]};
        cnt_r <= cnt_r - CNTW'(1);
      end
      S_NMAG: begin
        work_r <= alu_y[NW-1:0];
        qneg_r <= acc_r[NW] ^ dtr_e[DW-1];
        rem_r  <= '0;
        cnt_r  <= CNTW'(NW);
      end
      // Restoring divide: one quotient bit shifts into the numerator register.
      S_DIV: begin
        if (!alu_y[AW-1]) begin
          rem_r  <= alu_y[CB:0];
          work_r <= {work_r[NW-2:0], 1'b1};
        end else begin
          rem_r  <= {rem_r[CB-1:0], work_r[NW-1]};
          work_r <= {work_r[NW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CNTW'(1);
      end
      S_CLAMP: mag_r <= alu_y[AW-1] ? mcte_pkg::MAG_LIM : 64'(work_r);
      S_ADD:   sum_r <= alu_y[mcte_pkg::SUM_W-1:0];
      S_FIN: begin
        if (out_free) begin
          last_raw_r <= raw_r;
          last_te_r  <= te_r;
          last_tr_r  <= tr_r;
          if (first_r) begin
            est_r                      <= mcte_pkg::EST_W'(raw_r);
            last_dc_r                  <= '0;
            out_data_r.estimated_count <= mcte_pkg::EST_W'(raw_r);
            out_data_r.saturated       <= 1'b0;
          end else begin
            est_r                      <= est_clip;
            last_dc_r                  <= dc_r;
            out_data_r.estimated_count <= est_clip;
            out_data_r.saturated       <= !est_fits;
          end
        end
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

// Keeps its own copy of the estimator state, predicts one estimate per accepted
// sample and compares the estimates that come out in order.
class estimate_scoreboard;
  localparam logic signed [127:0] DELTA_LIM = {64'd0, mcte_pkg::MAG_LIM};

  logic [mcte_pkg::CNT_W-1:0]        last_raw;
  logic [mcte_pkg::CNT_W-1:0]        last_enabled;
  logic [mcte_pkg::CNT_W-1:0]        last_running;
  logic signed [mcte_pkg::CNT_W:0]   last_delta;
  logic signed [mcte_pkg::EST_W-1:0] estimate;
  logic [1:0]                        position;
  mcte_pkg::out_item_t               pending_estimates[$];
  int                                errors;
  int                                checked;
  int                                clamped;
  int                                series;

  function new();
    last_raw     = '0;
    last_enabled = '0;
    last_running = '0;
    last_delta   = '0;
    estimate     = '0;
    position     = mcte_pkg::POS_EMPTY;
    errors       = 0;
    checked      = 0;
    clamped      = 0;
    series       = 0;
  endfunction

  // Works out the estimate that an accepted sample must produce and queues it.
  function void note_sample(mcte_pkg::in_item_t s);
    logic signed [127:0] dc, dte, dtr, prev, num, step, total, hi_lim, lo_lim;
    mcte_pkg::out_item_t r;
    r.saturated = 1'b0;
    if (s.start_series || position == mcte_pkg::POS_EMPTY) begin
      // A new series starts from the raw count as it stands.
      estimate   = {{(mcte_pkg::EST_W-mcte_pkg::CNT_W){1'b0}}, s.raw_count};
      last_delta = '0;
      position   = mcte_pkg::POS_FIRST;
      series++;
    end else begin
      // Deltas are plain signed differences, so falling inputs give negative values.
      dc  = {{(128-mcte_pkg::CNT_W){1'b0}}, s.raw_count};
      dc  = dc - {{(128-mcte_pkg::CNT_W){1'b0}}, last_raw};
      dte = {{(128-mcte_pkg::CNT_W){1'b0}}, s.time_enabled};
      dte = dte - {{(128-mcte_pkg::CNT_W){1'b0}}, last_enabled};
      dtr = {{(128-mcte_pkg::CNT_W){1'b0}}, s.time_running};
      dtr = dtr - {{(128-mcte_pkg::CNT_W){1'b0}}, last_running};
      if (dtr == 0) begin
        dte = 1;
        dtr = 1;
      end
      prev = last_delta;
      if (position == mcte_pkg::POS_FIRST) begin
        num = dte * dc;
      end else begin
        num = dte * (prev + dc) + dtr * (prev - dc);
      end
      // Signed division truncates toward zero; the magnitude is then limited.
      step = num / (dtr + dtr);
      if (step > DELTA_LIM) begin
        step = DELTA_LIM;
      end else if (step < -DELTA_LIM) begin
        step = -DELTA_LIM;
      end
      hi_lim = mcte_pkg::EST_MAX;
      lo_lim = mcte_pkg::EST_MIN;
      total  = estimate;
      total  = total + step;
      if (total > hi_lim) begin
        total       = hi_lim;
        r.saturated = 1'b1;
      end else if (total < lo_lim) begin
        total       = lo_lim;
        r.saturated = 1'b1;
      end
      estimate   = total[mcte_pkg::EST_W-1:0];
      last_delta = dc[mcte_pkg::CNT_W:0];
      position   = mcte_pkg::POS_RUN;
    end
    last_raw          = s.raw_count;
    last_enabled      = s.time_enabled;
    last_running      = s.time_running;
    r.estimated_count = estimate;
    pending_estimates.push_back(r);
  endfunction

  // Compares an estimate leaving the block with the oldest one still waiting.
  function void check_estimate(mcte_pkg::out_item_t got);
    mcte_pkg::out_item_t want;
    if (pending_estimates.size() == 0) begin
      errors++;
      if (errors <= 10) begin
        $display("Unexpected estimate %0d (saturated %0b) with none pending",
                 got.estimated_count, got.saturated);
      end
      return;
    end
    want = pending_estimates.pop_front();
    checked++;
    if (want.saturated) begin
      clamped++;
    end
    if (got.estimated_count !== want.estimated_count || got.saturated !== want.saturated) begin
      errors++;
      if (errors <= 10) begin
        $display("Estimate %0d: expected %0d (saturated %0b), got %0d (saturated %0b)",
                 checked, want.estimated_count, want.saturated,
                 got.estimated_count, got.saturated);
      end
    end
  endfunction
endclass

module tb;
  localparam int RANDOM_ITEMS  = 1900;
  localparam int CALM_STRETCH  = 200;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 200;
  localparam logic [mcte_pkg::CNT_W-1:0] FULL = '1;
  localparam logic [mcte_pkg::CNT_W-1:0] ALT_A = 48'hAAAA_AAAA_AAAA;
  localparam logic [mcte_pkg::CNT_W-1:0] ALT_5 = 48'h5555_5555_5555;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  mcte_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  mcte_pkg::out_item_t out_data;

  estimate_scoreboard sb;
  int sent    = 0;
  int calm_at = 32'h7fff_ffff;
  int gap_pct = 25;
  bit calm    = 1'b0;

  multiplexed_counter_trapezoid_estimator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Every handshake is noted on the edge that completes it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_sample(in_data);
      end
      if (out_valid && !out_stall) begin
        sb.check_estimate(out_data);
      end
    end
  end

  // The run is abandoned if no item moves on either side for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("No item moved for %0d cycles", STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // The result side holds off in short bursts, with long free stretches in between.
  initial begin : result_stalls
    int pick;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (calm) begin
        out_stall <= 1'b0;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          repeat ($urandom_range(50, 300)) @(posedge clk);
        end else if (pick < 5) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 9)) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  function automatic logic [63:0] rand_bits(int w);
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return (w >= 64) ? v : v & ((64'd1 << w) - 64'd1);
  endfunction

  function automatic mcte_pkg::in_item_t make_sample(logic [mcte_pkg::CNT_W-1:0] raw,
                                                     logic [mcte_pkg::CNT_W-1:0] te,
                                                     logic [mcte_pkg::CNT_W-1:0] tr,
                                                     logic start);
    mcte_pkg::in_item_t s;
    s.raw_count    = raw;
    s.time_enabled = te;
    s.time_running = tr;
    s.start_series = start;
    return s;
  endfunction

  // Offers one sample, sometimes after a short gap, and waits until it is taken.
  task automatic send_sample(input mcte_pkg::in_item_t s);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    sent++;
    calm = (sent >= calm_at);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_estimates.size() != 0);
  endtask

  // A plausible series: times and counts grow, running time never outpaces enabled
  // time and sometimes stands still, and the count now and then drops back.
  task automatic play_series(input int len, input int scale, input bit fresh);
    logic [63:0] raw, te, tr, inc_en;
    raw = rand_bits(46);
    te  = rand_bits(46);
    tr  = te >> $urandom_range(0, 3);
    for (int k = 0; k < len; k++) begin
      if (k > 0) begin
        inc_en = rand_bits(scale);
        te     = te + inc_en;
        if ($urandom_range(0, 7) != 0) begin
          tr = tr + (inc_en >> $urandom_range(0, 4));
        end
        raw = raw + rand_bits(scale);
        if ($urandom_range(0, 15) == 0) begin
          raw = raw - rand_bits(scale);
        end
      end
      send_sample(make_sample(raw[mcte_pkg::CNT_W-1:0], te[mcte_pkg::CNT_W-1:0],
                              tr[mcte_pkg::CNT_W-1:0], (k == 0) ? fresh : 1'b0));
    end
  endtask

  initial begin : stimulus
    mcte_pkg::in_item_t directed[$];
    int base;
    int pick;
    int scale;
    bit paused;

    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed samples: no series yet, ratio one and above, a standing running time,
    // falling inputs, a restart mid-series, field extremes, clamping both ways, and
    // odd quotients that truncate toward zero.
    directed.push_back(make_sample(100, 10, 10, 1'b0));
    directed.push_back(make_sample(200, 20, 20, 1'b0));
    directed.push_back(make_sample(350, 40, 25, 1'b0));
    directed.push_back(make_sample(400, 50, 25, 1'b0));
    directed.push_back(make_sample(380, 45, 20, 1'b0));
    directed.push_back(make_sample(500, 60, 30, 1'b0));
    directed.push_back(make_sample(7, 1000, 1000, 1'b1));
    directed.push_back(make_sample(13, 1003, 1000, 1'b0));
    directed.push_back(make_sample(FULL, FULL, FULL, 1'b1));
    directed.push_back(make_sample(0, 0, 0, 1'b1));
    directed.push_back(make_sample(FULL, FULL, 1, 1'b0));
    directed.push_back(make_sample(FULL, FULL, 2, 1'b0));
    directed.push_back(make_sample(0, 0, 0, 1'b0));
    directed.push_back(make_sample(FULL, 0, 1, 1'b1));
    directed.push_back(make_sample(0, FULL, 2, 1'b0));
    directed.push_back(make_sample(1, 1, 1, 1'b1));
    directed.push_back(make_sample(2, 3, 2, 1'b0));
    directed.push_back(make_sample(4, 9, 3, 1'b0));
    directed.push_back(make_sample(5, 11, 3, 1'b0));
    directed.push_back(make_sample(10, 5, 5, 1'b1));
    directed.push_back(make_sample(4, 10, 10, 1'b0));
    directed.push_back(make_sample(1, 12, 11, 1'b0));
    directed.push_back(make_sample(ALT_A, ALT_5, ALT_A, 1'b1));
    directed.push_back(make_sample(ALT_5, ALT_A, ALT_5, 1'b0));
    foreach (directed[i]) begin
      send_sample(directed[i]);
    end
    hold_until_drained();

    // Random part: mostly well-formed series, some without their start flag, some noise.
    base    = sent;
    calm_at = base + RANDOM_ITEMS - CALM_STRETCH;
    paused  = 1'b0;
    while (sent < base + RANDOM_ITEMS) begin
      gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 25;
      if (!paused && sent >= base + RANDOM_ITEMS / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
      case ($urandom_range(0, 3))
        0: scale = 8;
        1: scale = 20;
        2: scale = 32;
        default: scale = 47;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        play_series($urandom_range(1, 40), scale, 1'b1);
      end else if (pick < 88) begin
        play_series($urandom_range(2, 20), scale, 1'b0);
      end else begin
        repeat ($urandom_range(1, 5)) begin
          send_sample(make_sample(mcte_pkg::CNT_W'(rand_bits(mcte_pkg::CNT_W)),
                                  mcte_pkg::CNT_W'(rand_bits(mcte_pkg::CNT_W)),
                                  mcte_pkg::CNT_W'(rand_bits(mcte_pkg::CNT_W)),
                                  $urandom_range(0, 3) == 0));
        end
      end
    end

    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d samples in %0d series; %0d estimates checked, %0d clamped.",
             sent, sb.series, sb.checked, sb.clamped);
    $display("Both sides idled in random bursts, with a drained pause and a quiet finish.");
    if (sb.errors == 0 && sb.pending_estimates.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d estimates outstanding",
               sb.errors, sb.pending_estimates.size());
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
